// ----- hw/rtl/itp_pkg.sv -----
package itp_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    // Class of the accepted input character
    typedef enum logic [2:0] {
        RQ_OPERAND,
        RQ_LPAREN,
        RQ_RPAREN,
        RQ_OPER,
        RQ_END
    } req_class_t;

    // Stacked operator codes
    localparam logic [2:0] CODE_PLUS   = 3'd0;
    localparam logic [2:0] CODE_MINUS  = 3'd1;
    localparam logic [2:0] CODE_MUL    = 3'd2;
    localparam logic [2:0] CODE_DIV    = 3'd3;
    localparam logic [2:0] CODE_MOD    = 3'd4;
    localparam logic [2:0] CODE_POW    = 3'd5;
    localparam logic [2:0] CODE_LPAREN = 3'd6;
    localparam logic [2:0] CODE_NONE   = 3'd7;

    // ASCII characters
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_MUL    = 8'h2A;
    localparam logic [7:0] CHAR_DIV    = 8'h2F;
    localparam logic [7:0] CHAR_MOD    = 8'h25;
    localparam logic [7:0] CHAR_POW    = 8'h5E;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Operator character to code, CODE_NONE for anything else
    function automatic logic [2:0] op_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            CHAR_PLUS:  code = CODE_PLUS;
            CHAR_MINUS: code = CODE_MINUS;
            CHAR_MUL:   code = CODE_MUL;
            CHAR_DIV:   code = CODE_DIV;
            CHAR_MOD:   code = CODE_MOD;
            CHAR_POW:   code = CODE_POW;
            default:    code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Code back to its character
    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            CODE_PLUS:   ch = CHAR_PLUS;
            CODE_MINUS:  ch = CHAR_MINUS;
            CODE_MUL:    ch = CHAR_MUL;
            CODE_DIV:    ch = CHAR_DIV;
            CODE_MOD:    ch = CHAR_MOD;
            CODE_POW:    ch = CHAR_POW;
            CODE_LPAREN: ch = CHAR_LPAREN;
            default:     ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    // Precedence: ( 0, + - 1, * / % 2, ^ 3
    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] prec;
        case (code)
            CODE_PLUS, CODE_MINUS:         prec = 2'd1;
            CODE_MUL, CODE_DIV, CODE_MOD:  prec = 2'd2;
            CODE_POW:                      prec = 2'd3;
            default:                       prec = 2'd0;
        endcase
        return prec;
    endfunction

endpackage

// ----- hw/rtl/infix_to_postfix_converter_unit.sv -----
// Shunting-yard infix to postfix converter: one expression character per input
// transaction, postfix characters out, operators held in an on-chip stack of
// STACK_DEPTH entries (a memory with a registered read port; its contents are
// not cleared at reset, only the fill count is). The unit takes one item at a
// time. An operand or '(' goes straight to the closing step; an operator, ')'
// or end item first passes through a read state and a check state for each
// stack entry it pops and emits, and once more for a stack entry that ends the
// pops (a lower-precedence operator or the matching '('). Each entry is read
// from the stack memory and then compared against the incoming operator's
// precedence in a separate cycle. A stall on the m_ side holds a pop or the closing step.
// The final result of each item carries m_last_of_run; one result is held back
// internally so that flag and the unmatched-')' error can be placed on it.
module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [1:0] m_error_code,
    output logic       m_last_of_run
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    // Stack memory
    logic [2:0] stack_mem [STACK_DEPTH];

    state_t          state_reg, state_next;
    req_class_t      class_reg, class_next;
    logic [2:0]      code_reg, code_next;
    logic [7:0]      char_reg, char_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            matched_reg, matched_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_char_reg, pend_char_next;
    logic [2:0]      rd_reg;

    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_out_char_reg, m_out_char_next;
    logic [1:0]      m_error_code_reg, m_error_code_next;
    logic            m_last_reg, m_last_next;

    logic            in_accept;
    logic            out_free;
    logic            out_load;
    logic [7:0]      out_char;
    logic [1:0]      out_err;
    logic            out_last;
    logic            push_en;
    logic [CNT_W-1:0] count_dec;
    req_class_t      in_class;

    logic            chk_stop;
    logic            chk_stall;
    logic            fin_push;
    logic            fin_full;
    logic            fin_emit;
    logic            fin_stall;
    logic [7:0]      fin_char;
    logic [1:0]      fin_err;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign count_dec = count_reg - CNT_W'(1);
    assign s_ready   = (state_reg == ST_IDLE);

    // Classify the incoming character
    always_comb begin
        if (s_kind) begin
            in_class = RQ_END;
        end else if (s_in_char == CHAR_LPAREN) begin
            in_class = RQ_LPAREN;
        end else if (s_in_char == CHAR_RPAREN) begin
            in_class = RQ_RPAREN;
        end else if (op_code(s_in_char) != CODE_NONE) begin
            in_class = RQ_OPER;
        end else begin
            in_class = RQ_OPERAND;
        end
    end

    // Top-of-stack decision
    always_comb begin
        case (class_reg)
            RQ_OPER:   chk_stop = (rd_reg == CODE_NONE) ||
                                  (code_prec(code_reg) > code_prec(rd_reg));
            RQ_RPAREN: chk_stop = (rd_reg == CODE_LPAREN);
            default:   chk_stop = 1'b0;
        endcase
    end
    assign chk_stall = !chk_stop && pend_valid_reg && !out_free;

    // Closing result of the item
    assign fin_push = (class_reg == RQ_LPAREN) || (class_reg == RQ_OPER);
    assign fin_full = (count_reg >= DEPTH_CNT);
    always_comb begin
        fin_emit = 1'b0;
        fin_char = CHAR_NUL;
        fin_err  = ERR_NONE;
        if (class_reg == RQ_OPERAND) begin
            fin_emit = 1'b1;
            fin_char = char_reg;
        end else if (fin_push && fin_full) begin
            fin_emit = 1'b1;
            fin_err  = ERR_OVERFLOW;
        end else if (class_reg == RQ_RPAREN && !matched_reg) begin
            fin_emit = 1'b1;
            fin_char = pend_valid_reg ? pend_char_reg : CHAR_NUL;
            fin_err  = ERR_UNMATCHED;
        end else if (pend_valid_reg) begin
            fin_emit = 1'b1;
            fin_char = pend_char_reg;
        end
    end
    assign fin_stall = fin_emit && !out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_class == RQ_OPERAND || in_class == RQ_LPAREN) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = (count_reg == '0) ? ST_FINISH : ST_CHECK;
            end
            ST_CHECK: begin
                if (chk_stop) begin
                    state_next = ST_FINISH;
                end else if (!chk_stall) begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (!fin_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result control
    always_comb begin
        class_next      = class_reg;
        code_next       = code_reg;
        char_next       = char_reg;
        count_next      = count_reg;
        matched_next    = matched_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_load        = 1'b0;
        out_char        = pend_char_reg;
        out_err         = ERR_NONE;
        out_last        = 1'b0;
        push_en         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    class_next      = in_class;
                    code_next       = (in_class == RQ_LPAREN) ? CODE_LPAREN
                                                              : op_code(s_in_char);
                    char_next       = s_in_char;
                    matched_next    = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_CHECK: begin
                if (chk_stop) begin
                    // matching '(' is popped and discarded
                    if (class_reg == RQ_RPAREN) begin
                        count_next   = count_dec;
                        matched_next = 1'b1;
                    end
                end else if (!chk_stall) begin
                    // pop: earlier held result goes out, this one is held
                    count_next      = count_dec;
                    pend_valid_next = 1'b1;
                    pend_char_next  = code_char(rd_reg);
                    out_load        = pend_valid_reg;
                end
            end
            ST_FINISH: begin
                if (!fin_stall) begin
                    out_load        = fin_emit;
                    out_char        = fin_char;
                    out_err         = fin_err;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    if (fin_push && !fin_full) begin
                        push_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_comb begin
        m_out_char_next   = m_out_char_reg;
        m_error_code_next = m_error_code_reg;
        m_last_next       = m_last_reg;
        if (out_load) begin
            m_valid_next      = 1'b1;
            m_out_char_next   = out_char;
            m_error_code_next = out_err;
            m_last_next       = out_last;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            matched_reg    <= 1'b0;
            class_reg      <= RQ_OPERAND;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            matched_reg    <= matched_next;
            class_reg      <= class_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        code_reg         <= code_next;
        char_reg         <= char_next;
        pend_char_reg    <= pend_char_next;
        m_out_char_reg   <= m_out_char_next;
        m_error_code_reg <= m_error_code_next;
        m_last_reg       <= m_last_next;
    end

    // Stack memory: write on push, registered read of the top entry
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[count_reg[IDX_W-1:0]] <= code_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_reg <= stack_mem[count_dec[IDX_W-1:0]];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_out_char_reg;
    assign m_error_code  = m_error_code_reg;
    assign m_last_of_run = m_last_reg;

    // Never push onto a full stack
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> (count_reg < DEPTH_CNT))
        else $error("push on full stack");

    // A stack entry is examined only when one exists
    a_check_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (count_reg != '0))
        else $error("stack check with empty stack");

    // The output register is never overwritten while holding a result
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwritten");

    // An accepted transaction blocks the input until it is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("input ready right after accept");

    // A held result never survives into a new item
    a_pend_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !pend_valid_reg)
        else $error("held result leaked into next item");

endmodule

// ----- bench/infix_to_postfix_converter_unit_tb.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;

    // One emitted postfix character as the unit should produce it
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] err;
        logic       run_end;
    } postfix_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_kind = 1'b0;
    logic [7:0] s_in_char = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic [1:0] m_error_code;
    logic       m_last_of_run;

    // Predictor state: operator stack and the result held back for its flags
    logic [2:0] op_stack [STACK_DEPTH];
    int         stack_fill = 0;
    postfix_t   held;
    logic       held_valid = 1'b0;
    int         run_len = 0;
    postfix_t   postfix_q [$];

    // Run control and statistics
    logic       no_idle = 1'b0;
    int         sink_hold_cycles = 0;
    logic       sink_holding = 1'b0;
    int         items_sent = 0;
    int         results_checked = 0;
    int         mismatch_count = 0;
    int         overflow_seen = 0;
    int         unmatched_seen = 0;
    int         longest_run = 0;
    postfix_t   want;

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_in_char    (s_in_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_error_code (m_error_code),
        .m_last_of_run(m_last_of_run)
    );

    always #6 aclk = ~aclk;

    // Operator character to stack code
    function automatic logic [2:0] code_of_char(input logic [7:0] c);
        case (c)
            CHAR_PLUS:  return CODE_PLUS;
            CHAR_MINUS: return CODE_MINUS;
            CHAR_MUL:   return CODE_MUL;
            CHAR_DIV:   return CODE_DIV;
            CHAR_MOD:   return CODE_MOD;
            CHAR_POW:   return CODE_POW;
            default:    return CODE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] char_of_code(input logic [2:0] code);
        case (code)
            CODE_PLUS:   return CHAR_PLUS;
            CODE_MINUS:  return CHAR_MINUS;
            CODE_MUL:    return CHAR_MUL;
            CODE_DIV:    return CHAR_DIV;
            CODE_MOD:    return CHAR_MOD;
            CODE_POW:    return CHAR_POW;
            CODE_LPAREN: return CHAR_LPAREN;
            default:     return CHAR_NUL;
        endcase
    endfunction

    // Binding strength; '(' is weakest so it stops every pop
    function automatic int rank_of_code(input logic [2:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS:         return 1;
            CODE_MUL, CODE_DIV, CODE_MOD:  return 2;
            CODE_POW:                      return 3;
            default:                       return 0;
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_MUL;
            3:       return CHAR_DIV;
            4:       return CHAR_MOD;
            default: return CHAR_POW;
        endcase
    endfunction

    // Any character that is neither an operator nor a parenthesis
    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'h20;
            1: c = 8'h61 + 8'($urandom_range(0, 25));
            default: begin
                do
                    c = 8'($urandom_range(0, 255));
                while (code_of_char(c) != CODE_NONE ||
                       c == CHAR_LPAREN || c == CHAR_RPAREN);
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Queue the previous result and hold this one, so flags can go on the last
    task automatic emit_postfix(input logic [7:0] c, input logic [1:0] err);
        if (held_valid)
            postfix_q.push_back(held);
        held = '{ch: c, err: err, run_end: 1'b0};
        held_valid = 1'b1;
        run_len++;
    endtask

    task automatic close_run();
        if (held_valid) begin
            held.run_end = 1'b1;
            postfix_q.push_back(held);
            held_valid = 1'b0;
        end
        if (run_len > longest_run)
            longest_run = run_len;
        run_len = 0;
    endtask

    task automatic push_operator(input logic [2:0] code);
        if (stack_fill >= STACK_DEPTH) begin
            emit_postfix(CHAR_NUL, ERR_OVERFLOW);
        end else begin
            op_stack[stack_fill] = code;
            stack_fill++;
        end
    endtask

    // Expected postfix output for one accepted transaction
    task automatic predict_postfix(input logic kind, input logic [7:0] c);
        logic [2:0] code;
        logic       matched;
        code = code_of_char(c);
        matched = 1'b0;
        if (kind) begin
            while (stack_fill > 0) begin
                stack_fill--;
                emit_postfix(char_of_code(op_stack[stack_fill]), ERR_NONE);
            end
        end else if (c == CHAR_LPAREN) begin
            push_operator(CODE_LPAREN);
        end else if (c == CHAR_RPAREN) begin
            while (stack_fill > 0 && !matched) begin
                stack_fill--;
                if (op_stack[stack_fill] == CODE_LPAREN)
                    matched = 1'b1;
                else
                    emit_postfix(char_of_code(op_stack[stack_fill]), ERR_NONE);
            end
            // unmatched close: error flag rides on the last popped operator
            if (!matched) begin
                if (held_valid)
                    held.err = ERR_UNMATCHED;
                else
                    emit_postfix(CHAR_NUL, ERR_UNMATCHED);
            end
        end else if (code != CODE_NONE) begin
            while (stack_fill > 0 &&
                   rank_of_code(op_stack[stack_fill - 1]) >= rank_of_code(code)) begin
                stack_fill--;
                emit_postfix(char_of_code(op_stack[stack_fill]), ERR_NONE);
            end
            push_operator(code);
        end else begin
            emit_postfix(c, ERR_NONE);
        end
        close_run();
    endtask

    // Offer one transaction; valid stays up if the next one follows at once
    task automatic send_item(input logic kind, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_in_char <= c;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_postfix(kind, c);
        items_sent++;
    endtask

    task automatic sender_pause();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        sender_pause();
        while (postfix_q.size() > 0)
            @(posedge aclk);
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_item(1'b0, text[i]);
    endtask

    // Short expressions hitting every operator and the corner cases
    task automatic test_directed_cases();
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h20);
        send_text("()");                 // close right above its open
        send_item(1'b0, CHAR_RPAREN);    // close on an empty stack
        send_item(1'b1, 8'hFF);          // end with nothing stacked
        send_text("a*b^c^d/e%f-g");      // precedence and left-assoc power
        send_item(1'b0, CHAR_RPAREN);    // close with only '-' stacked
        send_text("(+");                 // operator over '(' pops nothing
        send_item(1'b1, 8'h00);          // leftover '(' comes out as a character
    endtask

    // Fill the stack, push twice into a full stack, then flush all of it
    task automatic test_stack_overflow();
        int   filled;
        logic top_is_paren;
        filled = 0;
        top_is_paren = 1'b0;
        while (filled < STACK_DEPTH) begin
            if (top_is_paren && filled < STACK_DEPTH - 1 && $urandom_range(0, 1)) begin
                send_item(1'b0, pick_operator());
                top_is_paren = 1'b0;
            end else begin
                send_item(1'b0, CHAR_LPAREN);
                top_is_paren = 1'b1;
            end
            filled++;
            if ($urandom_range(0, 3) == 0)
                send_item(1'b0, pick_operand());
        end
        send_item(1'b0, CHAR_LPAREN);
        send_item(1'b0, pick_operator());
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Result side stalls for a long stretch while operands keep coming
    task automatic test_output_backpressure();
        int k;
        sender_pause();
        sink_hold_cycles = 300;
        while (!sink_holding)
            @(posedge aclk);
        no_idle = 1'b1;
        for (k = 0; k < 40; k++)
            send_item(1'b0, pick_operand());
        no_idle = 1'b0;
    endtask

    // Well-formed expression with random nesting; some parens left open
    task automatic send_random_expression();
        int operands;
        int opened;
        int k;
        operands = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        opened = 0;
        for (k = 0; k < operands; k++) begin
            while (opened < 6 && $urandom_range(0, 3) == 0) begin
                send_item(1'b0, CHAR_LPAREN);
                opened++;
            end
            send_item(1'b0, pick_operand());
            while (opened > 0 && $urandom_range(0, 2) == 0) begin
                send_item(1'b0, CHAR_RPAREN);
                opened--;
            end
            if (k < operands - 1)
                send_item(1'b0, pick_operator());
        end
        while (opened > 0 && $urandom_range(0, 4) != 0) begin
            send_item(1'b0, CHAR_RPAREN);
            opened--;
        end
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Unstructured characters, stray closes and stray end markers
    task automatic send_noise(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 7))
                0:       send_item(1'b1, 8'($urandom_range(0, 255)));
                1, 2:    send_item(1'b0, CHAR_RPAREN);
                3, 4:    send_item(1'b0, pick_operator());
                5:       send_item(1'b0, CHAR_LPAREN);
                default: send_item(1'b0, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_random_expressions(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                send_noise($urandom_range(1, 8));
            else
                send_random_expression();
            if ($urandom_range(0, 15) == 0)
                wait_for_drain();
        end
        no_idle = 1'b0;
    endtask

    // Result side ready pattern, with an on-request long hold
    initial begin : result_sink
        int stall;
        int burst;
        @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                sink_holding = 1'b1;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
                sink_holding = 1'b0;
            end else begin
                stall = pick_gap();
                burst = $urandom_range(1, 8);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (postfix_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result char %02h err %0d last %0b",
                                          m_out_char, m_error_code, m_last_of_run));
            end else begin
                want = postfix_q.pop_front();
                results_checked++;
                if (want.err == ERR_OVERFLOW)
                    overflow_seen++;
                if (want.err == ERR_UNMATCHED)
                    unmatched_seen++;
                if (m_out_char !== want.ch)
                    report_mismatch($sformatf("out_char %02h, expected %02h",
                                              m_out_char, want.ch));
                if (m_error_code !== want.err)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              m_error_code, want.err));
                if (m_last_of_run !== want.run_end)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              m_last_of_run, want.run_end));
            end
        end
    end

    // Ends the run if nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, postfix_q.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : main_sequence
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        wait_for_drain();
        test_stack_overflow();
        wait_for_drain();
        test_output_backpressure();
        wait_for_drain();
        test_random_expressions(330);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (postfix_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", postfix_q.size()));
        $display("Sent %0d expression characters, checked %0d postfix results, longest run %0d.",
                 items_sent, results_checked, longest_run);
        $display("Full-stack drops %0d, unmatched closes %0d, with random stalls on both sides.",
                 overflow_seen, unmatched_seen);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
